@@ hdl/siphash_2_4_engine_top_macros.svh @@
// ----------------------------------------------------------------------------
// siphash_2_4_engine_top_macros.svh
// Assertion macros shared by the engine's checker.
// ----------------------------------------------------------------------------
`ifndef SIPHASH_2_4_ENGINE_TOP_MACROS_SVH
`define SIPHASH_2_4_ENGINE_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SH24_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sh24 check failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define SH24_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sh24 check failed: next-cycle implication");

`endif

@@ hdl/sh24_pkg.sv @@
// ----------------------------------------------------------------------------
// sh24_pkg
// Types, constants and helpers of the SipHash-2-4 engine.
// ----------------------------------------------------------------------------
package sh24_pkg;

    localparam int WORD_W  = 64;
    localparam int COUNT_W = 4;
    localparam int LEN_W   = 8;
    localparam int CFG_IDX_W = 1;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // configuration register indexes
    localparam t_cfg_idx CFG_KEY_HIGH = 1'b0;
    localparam t_cfg_idx CFG_KEY_LOW  = 1'b1;

    // initialization constants
    localparam t_word SIP_INIT0 = 64'h736f6d6570736575;
    localparam t_word SIP_INIT1 = 64'h646f72616e646f6d;
    localparam t_word SIP_INIT2 = 64'h6c7967656e657261;
    localparam t_word SIP_INIT3 = 64'h7465646279746573;
    localparam t_word SIP_FINAL_XOR = 64'h00000000000000ff;

    localparam t_count FULL_COUNT = 4'd8;

    typedef struct packed {
        t_word v0;
        t_word v1;
        t_word v2;
        t_word v3;
    } t_vstate;

    // control from sequencer to datapath
    typedef struct packed {
        logic xor_m_v3;   // message into v3 ahead of the round
        logic xor_m_v0;   // message into v0 after the round
        logic xor_ff_v2;  // finalization constant into v2 ahead of the round
        logic upd_state;  // take the round result into v0..v3
        logic load_tail;  // replace message with the length-only tail block
        logic load_hash;  // take the final xor into the output register
    } t_ctrl;

    // state after key load
    function automatic t_vstate sh24_init(input t_word key_high, input t_word key_low);
        t_vstate s;
        s.v0 = SIP_INIT0 ^ key_high;
        s.v1 = SIP_INIT1 ^ key_low;
        s.v2 = SIP_INIT2 ^ key_high;
        s.v3 = SIP_INIT3 ^ key_low;
        return s;
    endfunction

endpackage

@@ hdl/sh24_in_if.sv @@
// ----------------------------------------------------------------------------
// sh24_in_if
// Message word channel: valid/ready handshake with word, byte count, last.
// ----------------------------------------------------------------------------
interface sh24_in_if;
    logic              valid;
    logic              ready;
    sh24_pkg::t_word   data_word;
    sh24_pkg::t_count  byte_count;
    logic              last;

    modport source (output valid, output data_word, output byte_count, output last,
                    input ready);
    modport sink   (input valid, input data_word, input byte_count, input last,
                    output ready);
endinterface

@@ hdl/sh24_out_if.sv @@
// ----------------------------------------------------------------------------
// sh24_out_if
// Hash result channel: valid/ready handshake with the 64-bit hash.
// ----------------------------------------------------------------------------
interface sh24_out_if;
    logic            valid;
    logic            ready;
    sh24_pkg::t_word hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

@@ hdl/sh24_round.sv @@
// ----------------------------------------------------------------------------
// sh24_round
// One SipRound over v0..v3, with optional message and finalization xors
// applied on the way in.
// ----------------------------------------------------------------------------
module sh24_round (
    input  sh24_pkg::t_vstate i_state,
    input  sh24_pkg::t_word   i_msg,
    input  logic              i_xor_m_v3,
    input  logic              i_xor_ff_v2,
    output sh24_pkg::t_vstate o_state
);
    import sh24_pkg::*;

    t_word a0, a1, a2, a3;
    t_word b0, b1, b2, b3;
    t_word c0, c1, c2, c3;

    // input xors
    always_comb begin
        a0 = i_state.v0;
        a1 = i_state.v1;
        a2 = i_xor_ff_v2 ? (i_state.v2 ^ SIP_FINAL_XOR) : i_state.v2;
        a3 = i_xor_m_v3 ? (i_state.v3 ^ i_msg) : i_state.v3;
    end

    // first half round
    always_comb begin
        b0 = a0 + a1;
        b1 = {a1[50:0], a1[63:51]} ^ b0;
        b0 = {b0[31:0], b0[63:32]};
        b2 = a2 + a3;
        b3 = {a3[47:0], a3[63:48]} ^ b2;
    end

    // second half round
    always_comb begin
        c0 = b0 + b3;
        c3 = {b3[42:0], b3[63:43]} ^ c0;
        c2 = b2 + b1;
        c1 = {b1[46:0], b1[63:47]} ^ c2;
        c2 = {c2[31:0], c2[63:32]};
    end

    assign o_state = '{v0: c0, v1: c1, v2: c2, v3: c3};

endmodule

@@ hdl/sh24_seq.sv @@
// ----------------------------------------------------------------------------
// sh24_seq
// Sequencer: two compression rounds per block, optional tail block,
// four finalization rounds, then the hash handoff.
// ----------------------------------------------------------------------------
module sh24_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_xfer,
    input  logic            i_in_last,
    input  logic            i_in_full,
    input  logic            i_out_busy,
    output logic            o_in_ready,
    output sh24_pkg::t_ctrl o_ctrl
);
    import sh24_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP1,
        S_CMP2,
        S_FIN
    } t_state;

    t_state     r_state;
    logic       r_last;
    logic       r_tail_pend;
    logic [1:0] r_fin_cnt;

    logic fin_end;
    assign fin_end = (r_state == S_FIN) && (r_fin_cnt == 2'd3);

    // state and per-item flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 1'b0;
            r_tail_pend <= 1'b0;
            r_fin_cnt   <= 2'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_xfer) begin
                        r_last      <= i_in_last;
                        r_tail_pend <= i_in_last & i_in_full;
                        r_state     <= S_CMP1;
                    end
                end
                S_CMP1: begin
                    r_state <= S_CMP2;
                end
                S_CMP2: begin
                    if (r_tail_pend) begin
                        r_tail_pend <= 1'b0;
                        r_state     <= S_CMP1;
                    end else if (r_last) begin
                        r_fin_cnt <= 2'd0;
                        r_state   <= S_FIN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_FIN: begin
                    if (r_fin_cnt != 2'd3) begin
                        r_fin_cnt <= r_fin_cnt + 2'd1;
                    end else if (!i_out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // control decode
    always_comb begin
        o_ctrl.xor_m_v3  = (r_state == S_CMP1);
        o_ctrl.xor_m_v0  = (r_state == S_CMP2);
        o_ctrl.xor_ff_v2 = (r_state == S_FIN) && (r_fin_cnt == 2'd0);
        o_ctrl.upd_state = (r_state == S_CMP1) || (r_state == S_CMP2) ||
                           ((r_state == S_FIN) && !fin_end);
        o_ctrl.load_tail = (r_state == S_CMP2) && r_tail_pend;
        o_ctrl.load_hash = fin_end && !i_out_busy;
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ hdl/siphash_2_4_engine_top.sv @@
// ----------------------------------------------------------------------------
// siphash_2_4_engine_top
// Keyed SipHash-2-4 over little-endian 64-bit message words.
// ----------------------------------------------------------------------------
// One round unit, shared by compression and finalization, runs one SipRound
// per cycle unless stalled, so the round count sets the timing. A word that
// is not last keeps the engine busy for its two compression rounds. A last
// word with 0..7 valid bytes adds four finalization rounds. A last word with
// 8 valid bytes (or a byte count above 8, which counts as 8) also adds a tail
// block of two more rounds. The input is not ready while a word is in work
// and comes back in the cycle after the last busy cycle. The hash sits in an
// output register, and the engine only stalls on its last finalization round
// if a second hash is done before the first is taken. Writing either key
// register reloads v0..v3 from the key and clears the length, but the
// sequencer runs on; keys may only be written while the engine is idle.
// ----------------------------------------------------------------------------
module siphash_2_4_engine_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sh24_in_if.sink              i_in,
    sh24_out_if.source           o_out,
    input  logic                 i_cfg_wr_en,
    input  sh24_pkg::t_cfg_idx   i_cfg_addr,
    input  sh24_pkg::t_word      i_cfg_wr_data
);
    import sh24_pkg::*;

    t_word   r_key_high, n_key_high;
    t_word   r_key_low,  n_key_low;
    t_vstate r_v,        n_v;
    t_word   r_msg,      n_msg;
    t_len    r_len,      n_len;
    t_word   r_hash,     n_hash;
    logic    r_out_valid, n_out_valid;

    t_ctrl   ctrl;
    t_vstate rnd_out;
    logic    in_ready;
    logic    in_xfer;
    logic    in_full;
    t_count  cnt_sat;
    t_word   tail_mask;
    t_len    len_add;
    t_len    len_upd;
    logic    out_busy;

    assign in_xfer  = i_in.valid & in_ready;
    assign in_full  = i_in.byte_count[3];
    assign cnt_sat  = in_full ? FULL_COUNT : i_in.byte_count;
    assign out_busy = r_out_valid & ~o_out.ready;

    // sequencer
    sh24_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_xfer  (in_xfer),
        .i_in_last  (i_in.last),
        .i_in_full  (in_full),
        .i_out_busy (out_busy),
        .o_in_ready (in_ready),
        .o_ctrl     (ctrl)
    );

    // shared round unit
    sh24_round u_round (
        .i_state     (r_v),
        .i_msg       (r_msg),
        .i_xor_m_v3  (ctrl.xor_m_v3),
        .i_xor_ff_v2 (ctrl.xor_ff_v2),
        .o_state     (rnd_out)
    );

    // keep the valid low bytes of a partial last word
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            tail_mask[8*i +: 8] = (i < int'(cnt_sat)) ? 8'hff : 8'h00;
        end
    end

    // length after this transfer
    assign len_add = (!i_in.last || in_full) ? t_len'(FULL_COUNT) : t_len'(cnt_sat);
    assign len_upd = r_len + len_add;

    // next-state datapath
    always_comb begin
        n_key_high  = r_key_high;
        n_key_low   = r_key_low;
        n_v         = r_v;
        n_msg       = r_msg;
        n_len       = r_len;
        n_hash      = r_hash;
        n_out_valid = r_out_valid & ~o_out.ready;

        if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_KEY_HIGH: n_key_high = i_cfg_wr_data;
                CFG_KEY_LOW:  n_key_low  = i_cfg_wr_data;
                default:      n_key_high = r_key_high;
            endcase
            n_v   = sh24_init(n_key_high, n_key_low);
            n_len = '0;
        end else begin
            // word transfer: message block and length
            if (in_xfer) begin
                n_len = len_upd;
                if (!i_in.last || in_full) begin
                    n_msg = i_in.data_word;
                end else begin
                    n_msg = (i_in.data_word & tail_mask) | {len_upd, {(WORD_W-LEN_W){1'b0}}};
                end
            end
            // round result
            if (ctrl.upd_state) begin
                n_v = rnd_out;
                if (ctrl.xor_m_v0) begin
                    n_v.v0 = rnd_out.v0 ^ r_msg;
                end
            end
            // tail block after a full last word
            if (ctrl.load_tail) begin
                n_msg = {r_len, {(WORD_W-LEN_W){1'b0}}};
            end
            // hash out and reload from key
            if (ctrl.load_hash) begin
                n_hash      = rnd_out.v0 ^ rnd_out.v1 ^ rnd_out.v2 ^ rnd_out.v3;
                n_out_valid = 1'b1;
                n_v         = sh24_init(r_key_high, r_key_low);
                n_len       = '0;
            end
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high  <= '0;
            r_key_low   <= '0;
            r_v         <= sh24_init('0, '0);
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_key_high  <= n_key_high;
            r_key_low   <= n_key_low;
            r_v         <= n_v;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_msg  <= n_msg;
        r_hash <= n_hash;
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_hash;

endmodule

@@ hdl/sh24_checker.sv @@
// ----------------------------------------------------------------------------
// sh24_checker
// Port-level checks of the engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "siphash_2_4_engine_top_macros.svh"

module sh24_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_last,
    input logic i_out_valid,
    input logic i_out_ready
);
    logic in_xfer;
    assign in_xfer = i_in_valid & i_in_ready;

    // a pending hash stays offered until taken
    `SH24_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // engine goes busy right after taking a word
    `SH24_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, in_xfer, !i_in_ready)

    // a middle word gives no hash
    `SH24_ASSERT_NEXT(a_no_hash_mid, i_clk, i_rst_n, in_xfer && !i_in_last && !i_out_valid,
                      !i_out_valid)

    // a middle word is done after its two rounds, ready again on the cycle after
    `SH24_ASSERT_NOW(a_mid_two_cycles, i_clk, i_rst_n, in_xfer && !i_in_last, ##3 i_in_ready)

endmodule

bind siphash_2_4_engine_top sh24_checker u_sh24_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);
